>>> design/fpp_pkg.sv
// Shared types and widths for the fitness-proportional pool builder.
`default_nettype none

package fpp_pkg;

  // Field and datapath widths.
  localparam int SCORE_W = 16;
  localparam int SQ_W    = 31;
  localparam int SUM_W   = 36;
  localparam int CNT_W   = 7;
  localparam int MIDX_W  = 6;
  localparam int QUO_W   = 7;
  localparam int DIVD_W  = SUM_W + 1;
  localparam int DSR_W   = SUM_W + QUO_W - 1;

  // Write port from the front part into the weight store.
  typedef struct packed {
    logic              en;
    logic [MIDX_W-1:0] addr;
    logic [SQ_W-1:0]   data;
  } store_wr_t;

  // Pass request: member count and sum of squares of one population.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] sum;
  } pass_cmd_t;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

endpackage

`default_nettype wire

>>> design/fpp_front.sv
// Front part: accepts scores, squares them, fills the store and queues pass requests.
`default_nettype none

module fpp_front #(
  parameter int MAX_MEMBERS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [fpp_pkg::SCORE_W-1:0] fitness_score,
  input  wire logic                              last_member,
  input  wire logic                              pass_done,
  output logic                                   busy,
  output fpp_pkg::store_wr_t                     wr,
  output logic                                   push,
  output fpp_pkg::pass_cmd_t                     cmd
);

  logic                          accept;
  logic [fpp_pkg::SCORE_W-1:0]   raw;
  logic [fpp_pkg::SCORE_W-1:0]   mag;
  logic [2*fpp_pkg::SCORE_W-1:0] sq_full;
  logic [fpp_pkg::SQ_W-1:0]      sq_r;
  logic                          last_r;
  logic                          vld_r;
  logic [fpp_pkg::CNT_W-1:0]     count;
  logic [fpp_pkg::CNT_W-1:0]     count_next;
  logic [fpp_pkg::SUM_W-1:0]     sum;
  logic [fpp_pkg::SUM_W-1:0]     sum_next;
  logic                          room;

  assign accept = start && !busy;

  // Magnitude of the score and its square.
  always_comb begin
    raw     = fitness_score;
    mag     = raw[fpp_pkg::SCORE_W-1] ? (fpp_pkg::SCORE_W'(0) - raw) : raw;
    sq_full = mag * mag;
  end

  // Store slot, running count and sum after the registered item.
  always_comb begin
    room       = (count < fpp_pkg::CNT_W'(MAX_MEMBERS));
    count_next = room ? count + fpp_pkg::CNT_W'(1) : count;
    sum_next   = room ? fpp_pkg::SUM_W'(sum + fpp_pkg::SUM_W'(sq_r)) : sum;
  end

  assign wr.en   = vld_r && room;
  assign wr.addr = count[fpp_pkg::MIDX_W-1:0];
  assign wr.data = sq_r;
  assign push    = vld_r && last_r;
  assign cmd.n   = count_next;
  assign cmd.sum = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= 1'b0;
      count <= '0;
      sum   <= '0;
      busy  <= 1'b0;
    end else begin
      vld_r <= accept;
      if (vld_r) begin
        if (last_r) begin
          count <= '0;
          sum   <= '0;
        end else begin
          count <= count_next;
          sum   <= sum_next;
        end
      end
      // Busy from a last item until its pass has delivered its final result.
      if (accept && last_member) begin
        busy <= 1'b1;
      end else if (pass_done) begin
        busy <= 1'b0;
      end
    end
    if (accept) begin
      sq_r   <= sq_full[fpp_pkg::SQ_W-1:0];
      last_r <= last_member;
    end
  end

  // A last item in the square stage always finds the block busy.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    vld_r && last_r |-> busy)
    else $error("last item in flight while not busy");

  // The member count never exceeds the store depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= fpp_pkg::CNT_W'(MAX_MEMBERS))
    else $error("member count beyond store depth");

endmodule

`default_nettype wire

>>> design/fpp_cmd_fifo.sv
// Two-entry queue of pass requests between the front and back parts.
`default_nettype none

module fpp_cmd_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire fpp_pkg::pass_cmd_t din,
  input  wire logic               pop,
  output fpp_pkg::pass_cmd_t      dout,
  output logic                    empty
);

  fpp_pkg::pass_cmd_t entries [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         fill;

  assign dout  = entries[rd_ptr];
  assign empty = (fill == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  // No push into a full queue, no pop from an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> fill != 2'd2)
    else $error("pass queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != 2'd0)
    else $error("pass queue underflow");

endmodule

`default_nettype wire

>>> design/fpp_back.sv
// Back part: weight store and the pass that divides each weight and emits pool entries.
`default_nettype none

module fpp_back #(
  parameter int MAX_MEMBERS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fpp_pkg::store_wr_t          wr,
  input  wire fpp_pkg::pass_cmd_t          cmd,
  input  wire logic                        cmd_empty,
  output logic                             cmd_pop,
  output logic                             pass_done,
  output logic                             result_strobe,
  output logic [fpp_pkg::MIDX_W-1:0]       member_index,
  output logic                             status,
  output logic                             last_of_run
);

  localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV,
    S_EMIT,
    S_FLUSH
  } state_t;

  state_t                         state;
  logic [fpp_pkg::SQ_W-1:0]       store [MAX_MEMBERS];
  logic [fpp_pkg::SQ_W-1:0]       rd_data;
  logic [fpp_pkg::CNT_W-1:0]      n_r;
  logic [fpp_pkg::SUM_W-1:0]      sum_r;
  logic [fpp_pkg::CNT_W-1:0]      idx;
  logic [fpp_pkg::CNT_W-1:0]      idx_inc;
  logic [fpp_pkg::DIVD_W-1:0]     rem;
  logic [fpp_pkg::DSR_W-1:0]      dsr;
  logic [fpp_pkg::QUO_W-1:0]      quo;
  logic [2:0]                     bitc;
  logic                           fits;
  logic [fpp_pkg::MIDX_W-1:0]     held_idx;
  logic                           held_vld;

  assign cmd_pop = (state == S_IDLE) && !cmd_empty;
  assign idx_inc = idx + fpp_pkg::CNT_W'(1);
  assign fits    = (fpp_pkg::DSR_W'(rem) >= dsr);

  // Weight store: written by the front part, read with a registered port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr.addr[IDX_W-1:0]] <= wr.data;
    end
    if (state == S_READ) begin
      rd_data <= store[idx[IDX_W-1:0]];
    end
  end

  // Pass sequencer: read, scale by n, divide one quotient bit a cycle, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
      pass_done     <= 1'b0;
      held_vld      <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      pass_done     <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            n_r      <= cmd.n;
            sum_r    <= cmd.sum;
            idx      <= '0;
            held_vld <= 1'b0;
            if (cmd.sum == '0) begin
              // All scores zero: a single empty-pool result.
              result_strobe <= 1'b1;
              member_index  <= '0;
              status        <= fpp_pkg::STATUS_EMPTY;
              last_of_run   <= 1'b1;
              pass_done     <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_MUL;
        end
        S_MUL: begin
          rem   <= fpp_pkg::DIVD_W'(rd_data * n_r);
          dsr   <= {sum_r, (fpp_pkg::QUO_W-1)'(0)};
          quo   <= '0;
          bitc  <= 3'(fpp_pkg::QUO_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (fits) begin
            rem <= rem - dsr[fpp_pkg::DIVD_W-1:0];
          end
          quo  <= {quo[fpp_pkg::QUO_W-2:0], fits};
          dsr  <= dsr >> 1;
          bitc <= bitc - 3'd1;
          if (bitc == 3'd0) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (quo != '0) begin
            // Hold one entry back so the final one can carry last_of_run.
            if (held_vld) begin
              result_strobe <= 1'b1;
              member_index  <= held_idx;
              status        <= fpp_pkg::STATUS_OK;
              last_of_run   <= 1'b0;
            end
            held_idx <= idx[fpp_pkg::MIDX_W-1:0];
            held_vld <= 1'b1;
            quo      <= quo - fpp_pkg::QUO_W'(1);
          end else if (idx_inc == n_r) begin
            state <= S_FLUSH;
          end else begin
            idx   <= idx_inc;
            state <= S_READ;
          end
        end
        S_FLUSH: begin
          result_strobe <= 1'b1;
          member_index  <= held_idx;
          status        <= fpp_pkg::STATUS_OK;
          last_of_run   <= 1'b1;
          pass_done     <= 1'b1;
          held_vld      <= 1'b0;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An empty-pool result is the sole result of its run, at index zero.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status == fpp_pkg::STATUS_EMPTY |-> last_of_run && member_index == '0)
    else $error("malformed empty-pool result");

  // The end of a pass coincides with its final result.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    pass_done |-> result_strobe && last_of_run)
    else $error("pass ended without a final result");

  // A nonzero sum always yields at least one held entry before the flush.
  a_flush_held: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |-> held_vld)
    else $error("flush without a pending entry");

endmodule

`default_nettype wire

>>> design/fitness_proportional_pool_builder_top.sv
// Top level of the fitness-proportional pool builder.
// Scores are taken one per cycle while busy is low and written to the store in the cycle after acceptance.
// A last item raises busy; its pass reads each stored member, multiplies it by n, divides
// it in seven divide steps and emits that member's pool entries before the next member.
// The run ends with last_of_run; busy falls at the edge that ends that cycle, and
// results cannot stall. Reset clears the count, sum and pass queue; the weight store
// holds no reset value.
`default_nettype none

module fitness_proportional_pool_builder_top #(
  parameter int MAX_MEMBERS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [fpp_pkg::SCORE_W-1:0] fitness_score,
  input  wire logic                               last_member,
  output logic                                    result_strobe,
  output logic [fpp_pkg::MIDX_W-1:0]              member_index,
  output logic                                    status,
  output logic                                    last_of_run
);

  fpp_pkg::store_wr_t wr;
  fpp_pkg::pass_cmd_t push_cmd;
  fpp_pkg::pass_cmd_t head_cmd;
  logic               push;
  logic               pop;
  logic               empty;
  logic               pass_done;

  // Front part: intake, squaring, store writes and pass requests.
  fpp_front #(
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .fitness_score(fitness_score),
    .last_member  (last_member),
    .pass_done    (pass_done),
    .busy         (busy),
    .wr           (wr),
    .push         (push),
    .cmd          (push_cmd)
  );

  // Queue of pass requests.
  fpp_cmd_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_cmd),
    .pop  (pop),
    .dout (head_cmd),
    .empty(empty)
  );

  // Back part: store and pool emission.
  fpp_back #(
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .cmd          (head_cmd),
    .cmd_empty    (empty),
    .cmd_pop      (pop),
    .pass_done    (pass_done),
    .result_strobe(result_strobe),
    .member_index (member_index),
    .status       (status),
    .last_of_run  (last_of_run)
  );

endmodule

`default_nettype wire
